// ===== rtl/bfmc_pkg.sv =====
// ----------------------------------------------------------------------------
// bfmc_pkg
// shared types and constants of the box filter mip chain
// ----------------------------------------------------------------------------
package bfmc_pkg;

  localparam int NSTG = 4;
  localparam int NRES = 4;
  localparam int IN_W = 32;
  localparam int OUT_W = 48;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PW = 3;
  localparam int FIFO_CW = 4;

  typedef logic [3:0][7:0] pix_t;
  typedef logic [3:0][9:0] lsum_t;

  typedef struct packed {
    logic [2:0] level;
    logic [2:0] col;
    logic [2:0] row;
    pix_t       pix;
    logic       last;
  } res_t;

endpackage

// ===== rtl/bfmc_stage.sv =====
// ----------------------------------------------------------------------------
// bfmc_stage
// one 2x2 box filter level: position counters, pair register, line buffer
// ----------------------------------------------------------------------------
module bfmc_stage #(
  parameter int SIDE = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  logic           reach_i,
  input  bfmc_pkg::pix_t cur_i,
  output logic           prod_o,
  output bfmc_pkg::pix_t avg_o,
  output logic [2:0]     col_o,
  output logic [2:0]     row_o
);
  import bfmc_pkg::*;

  localparam int HALF = SIDE / 2;
  localparam int PW = $clog2(SIDE);
  localparam int AW = (HALF > 1) ? $clog2(HALF) : 1;
  localparam logic [PW:0] LIM = (PW + 1)'(2 * HALF);
  localparam logic [PW-1:0] LASTP = PW'(SIDE - 1);

  logic [PW-1:0] x_q, x_d, y_q, y_d;
  pix_t          pair_q;
  lsum_t         mem [HALF];
  lsum_t         lread_q;
  lsum_t         wsum;
  logic [AW-1:0] addr;
  logic [PW:0]   xs;
  logic [8:0]    xe, ye;
  logic          in_blk, step, wr_line;

  assign xs      = {1'b0, x_q} >> 1;
  assign addr    = AW'(xs);
  assign in_blk  = ({1'b0, x_q} < LIM) && ({1'b0, y_q} < LIM);
  assign step    = fire_i && reach_i;
  assign wr_line = step && in_blk && x_q[0] && !y_q[0];
  assign prod_o  = reach_i && in_blk && x_q[0] && y_q[0];

  assign xe    = 9'(x_q);
  assign ye    = 9'(y_q);
  assign col_o = xe[3:1];
  assign row_o = ye[3:1];

  for (genvar c = 0; c < 4; c++) begin : g_ch
    logic [9:0] tot;
    assign wsum[c]  = 10'(pair_q[c]) + 10'(cur_i[c]);
    assign tot      = lread_q[c] + 10'(pair_q[c]) + 10'(cur_i[c]);
    assign avg_o[c] = tot[9:2];
  end

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (step) begin
      if (x_q == LASTP) begin
        x_d = '0;
        y_d = (y_q == LASTP) ? '0 : y_q + PW'(1);
      end else begin
        x_d = x_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_blk && !x_q[0]) begin
      pair_q <= cur_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_line) begin
      mem[addr] <= wsum;
    end
    lread_q <= mem[addr];
  end

endmodule

// ===== rtl/bfmc_fifo.sv =====
// ----------------------------------------------------------------------------
// bfmc_fifo
// result queue, takes up to four results of one pixel at once
// ----------------------------------------------------------------------------
module bfmc_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_i,
  input  logic [bfmc_pkg::NRES-1:0]           wr_vld_i,
  input  bfmc_pkg::res_t [bfmc_pkg::NRES-1:0] wr_data_i,
  output logic                                space_o,
  output logic                                rd_valid_o,
  input  logic                                rd_ready_i,
  output bfmc_pkg::res_t                      rd_data_o
);
  import bfmc_pkg::*;

  res_t               mem [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [FIFO_CW-1:0] cnt_q, cnt_d, num;
  logic               pop;

  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem[rptr_q];
  assign space_o    = (cnt_q <= FIFO_CW'(FIFO_DEPTH - NRES));
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    num = '0;
    for (int j = 0; j < NRES; j++) begin
      num = num + FIFO_CW'(wr_vld_i[j]);
    end
    if (!wr_i) begin
      num = '0;
    end
    wptr_d = wptr_q + FIFO_PW'(num);
    rptr_d = pop ? rptr_q + FIFO_PW'(1) : rptr_q;
    cnt_d  = cnt_q + num - FIFO_CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < NRES; j++) begin
      if (wr_i && wr_vld_i[j]) begin
        mem[wptr_q + FIFO_PW'(j)] <= wr_data_i[j];
      end
    end
  end

endmodule

// ===== rtl/box_filter_mip_chain.sv =====
// ----------------------------------------------------------------------------
// box_filter_mip_chain
// streaming 2x2 box filter mip chain over one square rgba face
// ----------------------------------------------------------------------------
// Takes one source pixel per cycle. Each accepted pixel sits in an input
// register and, when the queue has room, runs through four cascaded filter
// levels in one pass; the zero to four result pixels it completes enter an
// eight-entry result queue together and leave one beat per cycle. A pixel is
// taken whenever the queue has room for four results, so the sustained input
// rate is one pixel per cycle as long as the sink drains the queue; results
// average about one third of a beat per pixel. Each level keeps its upper
// block row sums in a line buffer of side/2 entries; no clearing pass is run.
module box_filter_mip_chain #(
  parameter int FACE_SIZE = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // red, green, blue, alpha
  input  logic [bfmc_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // level, out_x, out_y, red_out, green_out, blue_out, alpha_out, zero fill
  output logic [bfmc_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                       m_axis_tlast
);
  import bfmc_pkg::*;

  pix_t                  pix_q;
  logic                  vld_q, vld_d;
  logic                  fire, space;
  logic [NSTG-1:0]       prod, reach;
  pix_t [NSTG-1:0]       cur, avg;
  logic [NSTG-1:0][2:0]  col, row;
  res_t [NRES-1:0]       res;
  res_t                  head;

  assign fire          = vld_q && space;
  assign s_axis_tready = !vld_q || fire;

  always_comb begin
    vld_d = vld_q;
    if (s_axis_tvalid && s_axis_tready) begin
      vld_d = 1'b1;
    end else if (fire) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      pix_q <= s_axis_tdata;
    end
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    if (k == 0) begin : g_first
      assign reach[k] = 1'b1;
      assign cur[k]   = pix_q;
    end else begin : g_next
      assign reach[k] = prod[k-1];
      assign cur[k]   = avg[k-1];
    end

    if ((FACE_SIZE >> k) >= 2) begin : g_on
      bfmc_stage #(
        .SIDE(FACE_SIZE >> k)
      ) u_stage (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .fire_i (fire),
        .reach_i(reach[k]),
        .cur_i  (cur[k]),
        .prod_o (prod[k]),
        .avg_o  (avg[k]),
        .col_o  (col[k]),
        .row_o  (row[k])
      );
    end else begin : g_off
      assign prod[k] = 1'b0;
      assign avg[k]  = '0;
      assign col[k]  = '0;
      assign row[k]  = '0;
    end

    assign res[k].level = 3'(k + 1);
    assign res[k].col   = col[k];
    assign res[k].row   = row[k];
    assign res[k].pix   = avg[k];
    if (k < NSTG - 1) begin : g_mid
      assign res[k].last = prod[k] && !prod[k+1];
    end else begin : g_top
      assign res[k].last = prod[k];
    end
  end

  bfmc_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (fire),
    .wr_vld_i  (prod),
    .wr_data_i (res),
    .space_o   (space),
    .rd_valid_o(m_axis_tvalid),
    .rd_ready_i(m_axis_tready),
    .rd_data_o (head)
  );

  assign m_axis_tdata = {7'd0, head.pix[3], head.pix[2], head.pix[1], head.pix[0],
                         head.row, head.col, head.level};
  assign m_axis_tlast = head.last;

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("result run broken before its last beat");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] != 3'd0) && (m_axis_tdata[2:0] <= 3'd4))
    else $error("result level out of range");

  a_pass_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && prod[0] |=> m_axis_tvalid)
    else $error("results of a pass not offered");

endmodule
